// ===== hw/rtl/max_flow_edmonds_karp_defines.svh =====
// assertion helpers shared by the checker
`ifndef MAX_FLOW_EDMONDS_KARP_DEFINES_SVH
`define MAX_FLOW_EDMONDS_KARP_DEFINES_SVH

// clocked assertion, muted while reset is asserted
`define EK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked in the following cycle
`define EK_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/mfek_pkg.sv =====
package mfek_pkg;
	localparam int NODE_W = 4;
	localparam int CAPIN_W = 16;
	localparam int FLOW_W = 20;
	localparam int CNT_W = 5;
	localparam logic [FLOW_W-1:0] FLOW_MAX = '1;
	localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(16);
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_RUN = 1'b1;

	typedef struct packed {
		logic valid;
		logic [FLOW_W-1:0] flow;
	} mfek_res_t;
endpackage

// ===== hw/rtl/max_flow_edmonds_karp.sv =====
// channel     dir  handshake                 payload
// s (items)   in   s_tvalid / s_tready       tuser = mode, tdata = nodes and capacity
// m (result)  out  m_tvalid / m_tready       tdata = max_flow
// cfg         in   cfg_we                    cfg_wdata = node_count
//
// a load transaction is written into the capacity memory as it is accepted; a run copies
// the capacity memory into the residual memory, then per augmenting path runs a BFS scan
// and walks the path back twice, first for the bottleneck and then to update residuals
// after reset a clearing pass over all MAX_NODES*MAX_NODES cells zeroes the capacity
// memory, s_tready stays low meanwhile
// s_tready is low for the whole run; a finished result sits in the output
// register and the next item is accepted while it waits
module max_flow_edmonds_karp import mfek_pkg::*; #(
	parameter int MAX_NODES = 16,
	parameter int CAP_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata,  // from_node, to_node, capacity, source_node, sink_node
	input  logic s_tuser,         // mode
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,  // max_flow, zero pad
	input  logic cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);
	localparam int NW = $clog2(MAX_NODES);
	localparam int CELLS = MAX_NODES * MAX_NODES;
	localparam int AW = $clog2(CELLS);

	logic [CNT_W-1:0] node_count_q;
	logic [NW:0] n_use;
	logic in_acc, core_ready, res_take;
	mfek_res_t res;
	logic m_tvalid_q;
	logic [FLOW_W-1:0] m_flow_q;

	logic cap_we, res_we;
	logic [AW-1:0] cap_waddr, cap_raddr, res_waddr, res_raddr;
	logic [CAP_BITS-1:0] cap_wdata, cap_rdata;
	logic [CAP_BITS:0] res_wdata, res_rdata;

	// node count register; n_use clamps its value into the range 2..MAX_NODES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (32'(node_count_q) < 2) begin
			n_use = (NW+1)'(2);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n_use = (NW+1)'(MAX_NODES);
		end else begin
			n_use = (NW+1)'(node_count_q);
		end
	end

	assign s_tready = core_ready;
	assign in_acc = s_tvalid && core_ready;
	// result register frees the core as soon as it can load
	assign res_take = res.valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_flow_q <= res.flow;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {4'b0, m_flow_q};

	mfek_ram #(.DEPTH(CELLS), .WIDTH(CAP_BITS)) u_cap_ram (
		.clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
		.raddr(cap_raddr), .rdata(cap_rdata)
	);

	mfek_ram #(.DEPTH(CELLS), .WIDTH(CAP_BITS + 1)) u_res_ram (
		.clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
		.raddr(res_raddr), .rdata(res_rdata)
	);

	mfek_core #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_acc(in_acc),
		.in_mode(s_tuser),
		.in_from(s_tdata[3:0]),
		.in_to(s_tdata[7:4]),
		.in_cap(s_tdata[23:8]),
		.in_src(s_tdata[27:24]),
		.in_dst(s_tdata[31:28]),
		.n_use(n_use),
		.ready(core_ready),
		.res(res),
		.res_take(res_take),
		.cap_we(cap_we),
		.cap_waddr(cap_waddr),
		.cap_wdata(cap_wdata),
		.cap_raddr(cap_raddr),
		.cap_rdata(cap_rdata),
		.res_we(res_we),
		.res_waddr(res_waddr),
		.res_wdata(res_wdata),
		.res_raddr(res_raddr),
		.res_rdata(res_rdata)
	);
endmodule

// ===== hw/rtl/mfek_ram.sv =====
module mfek_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/mfek_core.sv =====
module mfek_core import mfek_pkg::*; #(
	parameter int MAX_NODES = 16,
	parameter int CAP_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_acc,
	input  logic in_mode,
	input  logic [NODE_W-1:0] in_from,
	input  logic [NODE_W-1:0] in_to,
	input  logic [CAPIN_W-1:0] in_cap,
	input  logic [NODE_W-1:0] in_src,
	input  logic [NODE_W-1:0] in_dst,
	input  logic [$clog2(MAX_NODES):0] n_use,
	output logic ready,
	output mfek_res_t res,
	input  logic res_take,
	output logic cap_we,
	output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] cap_waddr,
	output logic [CAP_BITS-1:0] cap_wdata,
	output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] cap_raddr,
	input  logic [CAP_BITS-1:0] cap_rdata,
	output logic res_we,
	output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] res_waddr,
	output logic [CAP_BITS:0] res_wdata,
	output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] res_raddr,
	input  logic [CAP_BITS:0] res_rdata
);
	localparam int NW = $clog2(MAX_NODES);
	localparam int CELLS = MAX_NODES * MAX_NODES;
	localparam int AW = $clog2(CELLS);
	localparam int RW = CAP_BITS + 1;
	localparam int SW = ((RW > FLOW_W) ? RW : FLOW_W) + 1;
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_CPY_RD, S_CPY_WR, S_BFS_INIT, S_POP, S_DEQ,
		S_SCAN_RD, S_SCAN_CHK, S_MIN_P, S_MIN_R, S_MIN_C,
		S_UPD_P, S_UPD_R, S_UPD_F, S_UPD_B, S_ACC, S_DONE
	} state_t;

	state_t state_q;
	logic [AW-1:0] cell_q;
	logic [NW-1:0] src_q, dst_q, u_q, v_q;
	logic [NW:0] head_q, tail_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [RW-1:0] bn_q;
	logic [FLOW_W-1:0] flow_q;
	logic [NW-1:0] queue_mem [MAX_NODES];
	logic [NW-1:0] pred_mem [MAX_NODES];
	logic [NW-1:0] q_rd_q, p_rd_q;
	logic q_we, p_we;
	logic [NW-1:0] q_wa, q_wd;
	logic [SW-1:0] flow_sum;
	logic hit, load_ok, run_bad;

	function automatic logic [AW-1:0] cell_idx(input logic [NW-1:0] r, input logic [NW-1:0] c);
		cell_idx = AW'(32'(r) * MAX_NODES + 32'(c));
	endfunction

	assign ready = (state_q == S_IDLE);
	assign hit = !visited_q[v_q] && (res_rdata != '0);
	assign load_ok = (32'(in_from) < MAX_NODES) && (32'(in_to) < MAX_NODES);
	assign run_bad = (32'(in_src) >= 32'(n_use)) || (32'(in_dst) >= 32'(n_use))
		|| (in_src == in_dst);
	assign flow_sum = SW'(flow_q) + SW'(bn_q);
	assign res.valid = (state_q == S_DONE);
	assign res.flow = flow_q;

	// memory port steering
	always_comb begin
		cap_we = 1'b0;
		cap_waddr = cell_q;
		cap_wdata = '0;
		cap_raddr = cell_q;
		res_we = 1'b0;
		res_waddr = cell_q;
		res_wdata = RW'(cap_rdata);
		res_raddr = cell_idx(u_q, v_q);
		q_we = 1'b0;
		q_wa = NW'(tail_q);
		q_wd = v_q;
		p_we = 1'b0;
		case (state_q)
			S_CLR: begin
				cap_we = 1'b1;
			end
			S_IDLE: begin
				cap_we = in_acc && (in_mode == MODE_LOAD) && load_ok;
				cap_waddr = AW'(32'(in_from) * MAX_NODES + 32'(in_to));
				cap_wdata = CAP_BITS'(in_cap);
			end
			S_CPY_WR: begin
				res_we = 1'b1;
			end
			S_BFS_INIT: begin
				q_we = 1'b1;
				q_wa = '0;
				q_wd = src_q;
			end
			S_SCAN_CHK: begin
				p_we = hit;
				q_we = hit && (v_q != dst_q) && (32'(tail_q) < MAX_NODES);
			end
			S_MIN_R, S_UPD_R: begin
				res_raddr = cell_idx(p_rd_q, v_q);
			end
			S_UPD_F: begin
				res_we = 1'b1;
				res_waddr = cell_idx(u_q, v_q);
				res_wdata = res_rdata - bn_q;
				res_raddr = cell_idx(v_q, u_q);
			end
			S_UPD_B: begin
				res_we = 1'b1;
				res_waddr = cell_idx(v_q, u_q);
				res_wdata = res_rdata + bn_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_wa] <= q_wd;
		end
		if (p_we) begin
			pred_mem[v_q] <= u_q;
		end
		q_rd_q <= queue_mem[NW'(head_q)];
		p_rd_q <= pred_mem[v_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cell_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			u_q <= '0;
			v_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			visited_q <= '0;
			bn_q <= '0;
			flow_q <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					cell_q <= cell_q + 1'b1;
					if (cell_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && (in_mode == MODE_RUN)) begin
						src_q <= NW'(in_src);
						dst_q <= NW'(in_dst);
						flow_q <= '0;
						cell_q <= '0;
						state_q <= run_bad ? S_DONE : S_CPY_RD;
					end
				end
				S_CPY_RD: begin
					state_q <= S_CPY_WR;
				end
				S_CPY_WR: begin
					cell_q <= cell_q + 1'b1;
					state_q <= (cell_q == LAST_CELL) ? S_BFS_INIT : S_CPY_RD;
				end
				S_BFS_INIT: begin
					visited_q <= MAX_NODES'(1) << src_q;
					head_q <= '0;
					tail_q <= (NW+1)'(1);
					state_q <= S_POP;
				end
				S_POP: begin
					state_q <= (head_q < tail_q) ? S_DEQ : S_DONE;
				end
				S_DEQ: begin
					u_q <= q_rd_q;
					head_q <= head_q + 1'b1;
					v_q <= '0;
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (hit && (v_q == dst_q)) begin
						bn_q <= '1;
						state_q <= S_MIN_P;
					end else begin
						if (hit) begin
							visited_q[v_q] <= 1'b1;
							if (32'(tail_q) < MAX_NODES) begin
								tail_q <= tail_q + 1'b1;
							end
						end
						if ((NW+1)'(v_q) == n_use - 1'b1) begin
							state_q <= S_POP;
						end else begin
							v_q <= v_q + 1'b1;
							state_q <= S_SCAN_RD;
						end
					end
				end
				// first walk back: bottleneck
				S_MIN_P: begin
					state_q <= S_MIN_R;
				end
				S_MIN_R: begin
					u_q <= p_rd_q;
					state_q <= S_MIN_C;
				end
				S_MIN_C: begin
					if (res_rdata < bn_q) begin
						bn_q <= res_rdata;
					end
					if (u_q == src_q) begin
						v_q <= dst_q;
						state_q <= S_UPD_P;
					end else begin
						v_q <= u_q;
						state_q <= S_MIN_P;
					end
				end
				// second walk back: residual update
				S_UPD_P: begin
					state_q <= S_UPD_R;
				end
				S_UPD_R: begin
					u_q <= p_rd_q;
					state_q <= S_UPD_F;
				end
				S_UPD_F: begin
					state_q <= S_UPD_B;
				end
				S_UPD_B: begin
					if (u_q == src_q) begin
						state_q <= S_ACC;
					end else begin
						v_q <= u_q;
						state_q <= S_UPD_P;
					end
				end
				S_ACC: begin
					flow_q <= (flow_sum > SW'(FLOW_MAX)) ? FLOW_MAX : FLOW_W'(flow_sum);
					state_q <= S_BFS_INIT;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/mfek_checker.sv =====
`include "max_flow_edmonds_karp_defines.svh"

module mfek_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [23:0] m_tdata
);
	`EK_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
	`EK_ASSERT(a_pad, m_tvalid |-> (m_tdata[23:20] == 4'b0), "pad bits set")
	`EK_ASSERT_NEXT(a_run_busy, s_tvalid && s_tready && s_tuser, !s_tready, "run not busy")
	`EK_ASSERT_NEXT(a_load_quiet, s_tvalid && s_tready && !s_tuser && !m_tvalid, !m_tvalid, "load gave result")
endmodule

bind max_flow_edmonds_karp mfek_checker u_mfek_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
